FILE: rtl/ffaea_pkg.sv
// Package: shared types, constants and helpers for the extent allocator.
package ffaea_pkg;

  localparam int unsigned MAX_EXTENTS_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF   = 32;
  localparam int unsigned SIZE_W          = 32;
  localparam logic [SIZE_W-1:0] SIZE_MAX  = '1;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_REALLOC = 2'd1,
    FN_FREE    = 2'd2,
    FN_RSVD    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MD_ALLOC,
    MD_GROW,
    MD_PUT
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_COMMIT,
    ST_REM_RD,
    ST_REM_WR,
    ST_MRG_RD,
    ST_MRG_EV,
    ST_INS_RD,
    ST_INS_WR,
    ST_DONE
  } state_e;

  function automatic logic [SIZE_W-1:0] sat_add(input logic [SIZE_W-1:0] a,
                                                input logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[SIZE_W] ? SIZE_MAX : s[SIZE_W-1:0];
  endfunction

endpackage

FILE: rtl/first_fit_aligned_extent_allocator.sv
// Top level: first-fit aligned extent allocator with a sequenced table walk.
// Each transaction runs a prepare step, then a read and an evaluate per extent scanned; a
// rewritten entry adds a write, an insert or removal a read and a write per entry shifted,
// and each merge check a read and an evaluate. The input is held off for the whole walk;
// the result register frees the input.
// Reset: extent table empty, no result pending; table RAM contents undefined.
module first_fit_aligned_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = ffaea_pkg::MAX_EXTENTS_DEF,
  parameter int unsigned ADDR_BITS   = ffaea_pkg::ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] chunk_addr_i,
  input  logic [31:0] chunk_size_i,
  input  logic [31:0] new_size_i,
  input  logic [4:0]  align_log2_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [31:0] out_addr_o,
  output logic [31:0] out_size_o,
  output logic [31:0] free_bytes_o,
  output logic        table_full_o
);
  import ffaea_pkg::*;

  localparam int unsigned AW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned SW = SIZE_W + CW;
  localparam int unsigned DW = ADDR_BITS + SIZE_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SIZE_W-1:0]    size_t;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic [1:0] func_q, func_d;
  logic [4:0] align_q, align_d;
  addr_t  caddr_q, caddr_d, cend_q, cend_d, cur_q, cur_d;
  size_t  csize_q, csize_d, size_q, size_d, delta_q, delta_d, mask_q, mask_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, jdx_q, jdx_d;
  logic [CW-1:0] rem_at_q, rem_at_d, ins_at_q, ins_at_d;
  addr_t  ent_b_q, ent_b_d, ins_b_q, ins_b_d;
  size_t  ent_l_q, ent_l_d, ins_l_q, ins_l_d;
  logic   p_wr_q, p_wr_d, p_rem_q, p_rem_d, p_mrg_q, p_mrg_d, p_ins_q, p_ins_d;
  logic   r_ok_q, r_ok_d, r_full_q, r_full_d;
  size_t  r_addr_q, r_addr_d, r_size_q, r_size_d;
  logic [SW-1:0] sum_q, sum_d;

  logic          ovalid_q, ovalid_d, ook_q, ook_d, ofull_q, ofull_d;
  size_t         oaddr_q, oaddr_d, osize_q, osize_d, ofree_q, ofree_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  addr_t         rb;
  size_t         rl, rb32, waste, tail, newl, nsize, pmask;
  addr_t         aaddr;
  logic          fits, ovf;

  ffaea_ram #(.WIDTH(DW), .DEPTH(MAX_EXTENTS)) u_tab (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rb    = rdata[DW-1:SIZE_W];
  assign rl    = rdata[SIZE_W-1:0];
  assign rb32  = SIZE_W'(rb);
  assign waste = (~rb32 + 32'd1) & mask_q;
  assign fits  = (waste <= rl) && ((rl - waste) >= size_q);
  assign tail  = rl - waste - size_q;
  assign aaddr = ADDR_BITS'(rb32 + waste);
  assign pmask = (32'd1 << align_q) - 32'd1;
  assign ovf   = size_q > ~pmask;
  assign nsize = (size_q + pmask) & ~pmask;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = ovalid_q;
  assign ok_o         = ook_q;
  assign out_addr_o   = oaddr_q;
  assign out_size_o   = osize_q;
  assign free_bytes_o = ofree_q;
  assign table_full_o = ofull_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      sum_q    <= '0;
      ovalid_q <= 1'b0;
      p_wr_q   <= 1'b0;
      p_rem_q  <= 1'b0;
      p_mrg_q  <= 1'b0;
      p_ins_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      ovalid_q <= ovalid_d;
      p_wr_q   <= p_wr_d;
      p_rem_q  <= p_rem_d;
      p_mrg_q  <= p_mrg_d;
      p_ins_q  <= p_ins_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    func_q   <= func_d;
    align_q  <= align_d;
    caddr_q  <= caddr_d;
    cend_q   <= cend_d;
    cur_q    <= cur_d;
    csize_q  <= csize_d;
    size_q   <= size_d;
    delta_q  <= delta_d;
    mask_q   <= mask_d;
    idx_q    <= idx_d;
    jdx_q    <= jdx_d;
    rem_at_q <= rem_at_d;
    ins_at_q <= ins_at_d;
    ent_b_q  <= ent_b_d;
    ent_l_q  <= ent_l_d;
    ins_b_q  <= ins_b_d;
    ins_l_q  <= ins_l_d;
    r_ok_q   <= r_ok_d;
    r_full_q <= r_full_d;
    r_addr_q <= r_addr_d;
    r_size_q <= r_size_d;
    ook_q    <= ook_d;
    ofull_q  <= ofull_d;
    oaddr_q  <= oaddr_d;
    osize_q  <= osize_d;
    ofree_q  <= ofree_d;
  end

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    func_d   = func_q;
    align_d  = align_q;
    caddr_d  = caddr_q;
    cend_d   = cend_q;
    cur_d    = cur_q;
    csize_d  = csize_q;
    size_d   = size_q;
    delta_d  = delta_q;
    mask_d   = mask_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    jdx_d    = jdx_q;
    rem_at_d = rem_at_q;
    ins_at_d = ins_at_q;
    ent_b_d  = ent_b_q;
    ent_l_d  = ent_l_q;
    ins_b_d  = ins_b_q;
    ins_l_d  = ins_l_q;
    p_wr_d   = p_wr_q;
    p_rem_d  = p_rem_q;
    p_mrg_d  = p_mrg_q;
    p_ins_d  = p_ins_q;
    r_ok_d   = r_ok_q;
    r_full_d = r_full_q;
    r_addr_d = r_addr_q;
    r_size_d = r_size_q;
    sum_d    = sum_q;
    ovalid_d = ovalid_q;
    ook_d    = ook_q;
    ofull_d  = ofull_q;
    oaddr_d  = oaddr_q;
    osize_d  = osize_q;
    ofree_d  = ofree_q;
    we       = 1'b0;
    waddr    = idx_q[AW-1:0];
    wdata    = {ent_b_q, ent_l_q};
    raddr    = idx_q[AW-1:0];
    newl     = '0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          align_d = align_log2_i;
          caddr_d = chunk_addr_i[ADDR_BITS-1:0];
          csize_d = chunk_size_i;
          size_d  = new_size_i;
          state_d = ST_PREP;
        end
      end

      ST_PREP: begin
        r_ok_d   = 1'b0;
        r_full_d = 1'b0;
        r_addr_d = '0;
        r_size_d = '0;
        idx_d    = '0;
        mask_d   = pmask;
        cend_d   = ADDR_BITS'(SIZE_W'(caddr_q) + csize_q);
        state_d  = ST_SCAN_RD;
        case (func_q)
          FN_ALLOC: begin
            mode_d = MD_ALLOC;
            size_d = nsize;
            if (align_q == '0 || ovf) begin
              state_d = ST_DONE;
            end
          end
          FN_REALLOC: begin
            r_addr_d = SIZE_W'(caddr_q);
            r_size_d = csize_q;
            size_d   = nsize;
            delta_d  = nsize - csize_q;
            ins_b_d  = ADDR_BITS'(SIZE_W'(caddr_q) + nsize);
            ins_l_d  = csize_q - nsize;
            mode_d   = (nsize > csize_q) ? MD_GROW : MD_PUT;
            if (ovf) begin
              state_d = ST_DONE;
            end else if (nsize == csize_q) begin
              r_ok_d   = 1'b1;
              r_size_d = nsize;
              state_d  = ST_DONE;
            end
          end
          FN_FREE: begin
            mode_d  = MD_PUT;
            ins_b_d = caddr_q;
            ins_l_d = csize_q;
          end
          default: state_d = ST_DONE;
        endcase
      end

      ST_SCAN_RD: begin
        if (idx_q >= cnt_q) begin
          state_d = ST_DONE;
          if (mode_q == MD_PUT) begin
            if (cnt_q >= CNT_MAX) begin
              r_full_d = 1'b1;
            end else begin
              r_ok_d   = 1'b1;
              ins_at_d = cnt_q;
              p_ins_d  = 1'b1;
              sum_d    = sum_q + SW'(ins_l_q);
              if (func_q == FN_REALLOC) r_size_d = size_q;
              state_d  = ST_COMMIT;
            end
          end
        end else begin
          state_d = ST_SCAN_EV;
        end
      end

      ST_SCAN_EV: begin
        state_d = ST_SCAN_RD;
        idx_d   = idx_q + 1'b1;
        case (mode_q)
          MD_ALLOC: begin
            if (fits) begin
              r_ok_d   = 1'b1;
              r_addr_d = SIZE_W'(aaddr);
              r_size_d = size_q;
              sum_d    = sum_q - SW'(size_q);
              idx_d    = idx_q;
              state_d  = ST_COMMIT;
              if (waste == '0) begin
                newl = rl - size_q;
                if (newl == '0) begin
                  p_rem_d  = 1'b1;
                  rem_at_d = idx_q;
                end else begin
                  p_wr_d  = 1'b1;
                  ent_b_d = ADDR_BITS'(rb32 + size_q);
                  ent_l_d = newl;
                end
              end else begin
                p_wr_d  = 1'b1;
                ent_b_d = rb;
                ent_l_d = waste;
                if (tail != '0) begin
                  if (cnt_q < CNT_MAX) begin
                    p_ins_d  = 1'b1;
                    ins_at_d = idx_q + 1'b1;
                    ins_b_d  = ADDR_BITS'(SIZE_W'(aaddr) + size_q);
                    ins_l_d  = tail;
                  end else begin
                    r_size_d = size_q + tail;
                    r_full_d = 1'b1;
                    sum_d    = sum_q - SW'(size_q) - SW'(tail);
                  end
                end
              end
            end
          end
          MD_GROW: begin
            if (rb == cend_q) begin
              idx_d   = idx_q;
              state_d = ST_DONE;
              if (delta_q <= rl) begin
                r_ok_d   = 1'b1;
                r_size_d = size_q;
                sum_d    = sum_q - SW'(delta_q);
                newl     = rl - delta_q;
                state_d  = ST_COMMIT;
                if (newl == '0) begin
                  p_rem_d  = 1'b1;
                  rem_at_d = idx_q;
                end else begin
                  p_wr_d  = 1'b1;
                  ent_b_d = ADDR_BITS'(rb32 + delta_q);
                  ent_l_d = newl;
                end
              end
            end
          end
          default: begin
            if (rb > caddr_q) begin
              idx_d   = idx_q;
              state_d = ST_COMMIT;
              if (rb == cend_q) begin
                newl     = sat_add(rl, ins_l_q);
                r_ok_d   = 1'b1;
                p_wr_d   = 1'b1;
                ent_b_d  = ins_b_q;
                ent_l_d  = newl;
                sum_d    = sum_q + SW'(newl) - SW'(rl);
                if (func_q == FN_REALLOC) r_size_d = size_q;
              end else if (cnt_q >= CNT_MAX) begin
                r_full_d = 1'b1;
                state_d  = ST_DONE;
              end else begin
                r_ok_d   = 1'b1;
                p_ins_d  = 1'b1;
                ins_at_d = idx_q;
                sum_d    = sum_q + SW'(ins_l_q);
                if (func_q == FN_REALLOC) r_size_d = size_q;
              end
            end else if (func_q == FN_FREE &&
                         ADDR_BITS'(rb32 + rl) == caddr_q) begin
              newl    = sat_add(rl, csize_q);
              idx_d   = idx_q;
              r_ok_d  = 1'b1;
              p_wr_d  = 1'b1;
              p_mrg_d = 1'b1;
              ent_b_d = rb;
              ent_l_d = newl;
              cur_d   = ADDR_BITS'(rb32 + newl);
              sum_d   = sum_q + SW'(newl) - SW'(rl);
              state_d = ST_COMMIT;
            end
          end
        endcase
      end

      ST_COMMIT: begin
        if (p_rem_q) begin
          jdx_d   = rem_at_q + 1'b1;
          state_d = ST_REM_RD;
        end else if (p_mrg_q) begin
          state_d = ST_MRG_RD;
        end else if (p_wr_q) begin
          we     = 1'b1;
          p_wr_d = 1'b0;
        end else if (p_ins_q) begin
          jdx_d   = cnt_q;
          state_d = ST_INS_RD;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_REM_RD: begin
        raddr = jdx_q[AW-1:0];
        if (jdx_q >= cnt_q) begin
          cnt_d   = cnt_q - 1'b1;
          p_rem_d = 1'b0;
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_REM_WR;
        end
      end

      ST_REM_WR: begin
        we      = 1'b1;
        waddr   = AW'(jdx_q - 1'b1);
        wdata   = rdata;
        jdx_d   = jdx_q + 1'b1;
        state_d = ST_REM_RD;
      end

      ST_MRG_RD: begin
        raddr = AW'(idx_q + 1'b1);
        if ((idx_q + 1'b1) >= cnt_q) begin
          p_mrg_d = 1'b0;
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_MRG_EV;
        end
      end

      ST_MRG_EV: begin
        state_d = ST_COMMIT;
        if (rb == cur_q) begin
          newl     = sat_add(ent_l_q, rl);
          ent_l_d  = newl;
          cur_d    = ADDR_BITS'(SIZE_W'(cur_q) + rl);
          sum_d    = sum_q + SW'(newl) - SW'(ent_l_q) - SW'(rl);
          p_rem_d  = 1'b1;
          rem_at_d = idx_q + 1'b1;
        end else begin
          p_mrg_d = 1'b0;
        end
      end

      ST_INS_RD: begin
        raddr = AW'(jdx_q - 1'b1);
        if (jdx_q == ins_at_q) begin
          we      = 1'b1;
          waddr   = ins_at_q[AW-1:0];
          wdata   = {ins_b_q, ins_l_q};
          cnt_d   = cnt_q + 1'b1;
          p_ins_d = 1'b0;
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_INS_WR;
        end
      end

      ST_INS_WR: begin
        we      = 1'b1;
        waddr   = jdx_q[AW-1:0];
        wdata   = rdata;
        jdx_d   = jdx_q - 1'b1;
        state_d = ST_INS_RD;
      end

      ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ook_d    = r_ok_q;
          ofull_d  = r_full_q;
          oaddr_d  = r_addr_q;
          osize_d  = r_size_q;
          ofree_d  = (sum_q > SW'(SIZE_MAX)) ? SIZE_MAX : sum_q[SIZE_W-1:0];
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_MAX)
    else $error("extent count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN_EV |-> idx_q < cnt_q)
    else $error("scan read beyond extent count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !p_wr_q && !p_rem_q && !p_mrg_q && !p_ins_q)
    else $error("table update left pending at end of transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && (!ovalid_q || out_ready_i) |=> out_valid_o)
    else $error("result not presented");
endmodule

FILE: rtl/ffaea_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffaea_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: tb/sv/tb_first_fit_aligned_extent_allocator.sv
// Testbench for the first-fit aligned extent allocator: directed and random transactions.
module tb_first_fit_aligned_extent_allocator;
  import ffaea_pkg::*;

  localparam int unsigned NEXT = 64;
  localparam int unsigned WDOG_LIMIT = 20000;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
    logic [31:0] size;
    logic [31:0] freeb;
    logic        full;
  } alloc_res_t;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] size;
    logic [4:0]  align;
  } chunk_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [31:0] chunk_addr_i;
  logic [31:0] chunk_size_i;
  logic [31:0] new_size_i;
  logic [4:0]  align_log2_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        ok_o;
  logic [31:0] out_addr_o;
  logic [31:0] out_size_o;
  logic [31:0] free_bytes_o;
  logic        table_full_o;

  first_fit_aligned_extent_allocator dut (.*);

  always #5 clk_i = ~clk_i;

  // Predicted free-extent table
  logic [31:0] pool_base[NEXT];
  logic [31:0] pool_len[NEXT];
  int          pool_cnt;

  alloc_res_t  expected_q[$];
  chunk_t      live_chunks[$];
  int          mismatches;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          rx_hold_req;
  int          rx_hold_left;
  int          stall_cycles;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void pool_remove(int i);
    for (int j = i; j < pool_cnt - 1; j++) begin
      pool_base[j] = pool_base[j+1];
      pool_len[j]  = pool_len[j+1];
    end
    pool_cnt--;
  endfunction

  function automatic void pool_insert(int i, logic [31:0] b, logic [31:0] l);
    for (int j = pool_cnt; j > i; j--) begin
      pool_base[j] = pool_base[j-1];
      pool_len[j]  = pool_len[j-1];
    end
    pool_base[i] = b;
    pool_len[i]  = l;
    pool_cnt++;
  endfunction

  function automatic logic [31:0] pool_total();
    logic [39:0] acc;
    acc = '0;
    for (int i = 0; i < pool_cnt; i++) acc += pool_len[i];
    return (acc > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
  endfunction

  function automatic logic take_first_fit(logic [31:0] size, logic [4:0] al,
                                          output logic [31:0] oa, output logic [31:0] os,
                                          inout logic full);
    logic [31:0] mask, waste, avail, a, tail;
    oa = '0;
    os = '0;
    if (al == 0) return 1'b0;
    mask = (32'd1 << al) - 32'd1;
    if ((size & mask) != 0) begin
      if (size > 32'hFFFF_FFFF - mask) return 1'b0;
      size = (size + mask) & ~mask;
    end
    for (int i = 0; i < pool_cnt; i++) begin
      waste = pool_base[i] & mask;
      if (waste > 0) waste = mask + 32'd1 - waste;
      if (waste > pool_len[i]) continue;
      avail = pool_len[i] - waste;
      if (avail < size) continue;
      a  = pool_base[i] + waste;
      oa = a;
      os = size;
      if (waste == 0) begin
        pool_base[i] = pool_base[i] + size;
        pool_len[i]  = pool_len[i] - size;
        if (pool_len[i] == 0) pool_remove(i);
      end else begin
        tail = avail - size;
        pool_len[i] = waste;
        if (tail != 0) begin
          if (pool_cnt < NEXT) pool_insert(i + 1, a + size, tail);
          else begin
            os   = size + tail;
            full = 1'b1;
          end
        end
      end
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic resize_chunk(logic [31:0] ca, logic [31:0] cs, logic [31:0] size,
                                        logic [4:0] al, output logic [31:0] os,
                                        inout logic full);
    logic [31:0] mask, ns, cend, added, fb, fs;
    int i;
    os   = '0;
    mask = (32'd1 << al) - 32'd1;
    cend = ca + cs;
    if (size > 32'hFFFF_FFFF - mask) return 1'b0;
    ns = (size + mask) & ~mask;
    if (ns == cs) begin
      os = ns;
      return 1'b1;
    end
    if (ns > cs) begin
      added = ns - cs;
      for (i = 0; i < pool_cnt; i++) if (pool_base[i] == cend) break;
      if (i == pool_cnt || added > pool_len[i]) return 1'b0;
      pool_base[i] = pool_base[i] + added;
      pool_len[i]  = pool_len[i] - added;
      if (pool_len[i] == 0) pool_remove(i);
      os = ns;
      return 1'b1;
    end
    fb = ca + ns;
    fs = cs - ns;
    for (i = 0; i < pool_cnt; i++) begin
      if (pool_base[i] > ca) begin
        if (pool_base[i] == cend) begin
          pool_base[i] = fb;
          pool_len[i]  = add_sat(pool_len[i], fs);
        end else begin
          if (pool_cnt >= NEXT) begin
            full = 1'b1;
            return 1'b0;
          end
          pool_insert(i, fb, fs);
        end
        os = ns;
        return 1'b1;
      end
    end
    if (pool_cnt >= NEXT) begin
      full = 1'b1;
      return 1'b0;
    end
    pool_insert(pool_cnt, fb, fs);
    os = ns;
    return 1'b1;
  endfunction

  function automatic logic return_chunk(logic [31:0] ca, logic [31:0] cs, inout logic full);
    logic [31:0] cend, c;
    cend = ca + cs;
    for (int i = 0; i < pool_cnt; i++) begin
      if (pool_base[i] > ca) begin
        if (pool_base[i] == cend) begin
          pool_base[i] = ca;
          pool_len[i]  = add_sat(pool_len[i], cs);
        end else begin
          if (pool_cnt >= NEXT) begin
            full = 1'b1;
            return 1'b0;
          end
          pool_insert(i, ca, cs);
        end
        return 1'b1;
      end
      if (pool_base[i] + pool_len[i] == ca) begin
        pool_len[i] = add_sat(pool_len[i], cs);
        c = pool_base[i] + pool_len[i];
        while (i + 1 < pool_cnt && pool_base[i+1] == c) begin
          pool_len[i] = add_sat(pool_len[i], pool_len[i+1]);
          c = c + pool_len[i+1];
          pool_remove(i + 1);
        end
        return 1'b1;
      end
    end
    if (pool_cnt >= NEXT) begin
      full = 1'b1;
      return 1'b0;
    end
    pool_insert(pool_cnt, ca, cs);
    return 1'b1;
  endfunction

  function automatic alloc_res_t predict_alloc(logic [1:0] fn, logic [31:0] ca, logic [31:0] cs,
                                               logic [31:0] ns, logic [4:0] al);
    alloc_res_t r;
    r = '0;
    case (fn)
      FN_ALLOC: begin
        r.ok = take_first_fit(ns, al, r.addr, r.size, r.full);
        if (!r.ok) begin
          r.addr = '0;
          r.size = '0;
        end
      end
      FN_REALLOC: begin
        r.ok   = resize_chunk(ca, cs, ns, al, r.size, r.full);
        r.addr = ca;
        if (!r.ok) r.size = cs;
      end
      FN_FREE: r.ok = return_chunk(ca, cs, r.full);
      default: ;
    endcase
    r.freeb = pool_total();
    return r;
  endfunction

  task automatic send_req(logic [1:0] fn, logic [31:0] ca, logic [31:0] cs,
                          logic [31:0] ns, logic [4:0] al, output alloc_res_t r);
    r = predict_alloc(fn, ca, cs, ns, al);
    expected_q.push_back(r);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i   <= 1'b1;
    func_i       <= fn;
    chunk_addr_i <= ca;
    chunk_size_i <= cs;
    new_size_i   <= ns;
    align_log2_i <= al;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic do_alloc_tx(logic [31:0] ns, logic [4:0] al);
    alloc_res_t r;
    chunk_t c;
    send_req(FN_ALLOC, $urandom, $urandom, ns, al, r);
    if (r.ok) begin
      c.addr = r.addr;
      c.size = r.size;
      c.align = al;
      live_chunks.push_back(c);
    end
  endtask

  task automatic do_realloc_tx(int idx, logic [31:0] ns);
    alloc_res_t r;
    send_req(FN_REALLOC, live_chunks[idx].addr, live_chunks[idx].size, ns,
             live_chunks[idx].align, r);
    if (r.ok) live_chunks[idx].size = r.size;
  endtask

  task automatic do_free_tx(int idx);
    alloc_res_t r;
    send_req(FN_FREE, live_chunks[idx].addr, live_chunks[idx].size, $urandom,
             5'($urandom), r);
    live_chunks.delete(idx);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    @(posedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    alloc_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction");
      end else begin
        e = expected_q.pop_front();
        if (ok_o !== e.ok || out_addr_o !== e.addr || out_size_o !== e.size ||
            free_bytes_o !== e.freeb || table_full_o !== e.full) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: exp ok=%0b addr=%h size=%h free=%h full=%0b, ",
                      "got ok=%0b addr=%h size=%h free=%h full=%0b"},
                     e.ok, e.addr, e.size, e.freeb, e.full,
                     ok_o, out_addr_o, out_size_o, free_bytes_o, table_full_o);
        end
      end
    end
  end

  // Result-side back-pressure
  always @(posedge clk_i) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      stall_cycles = 0;
    else if (++stall_cycles >= WDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_empty_pool();
    alloc_res_t r;
    send_req(FN_ALLOC, 32'h0, 32'h0, 32'd16, 5'd1, r);
    send_req(FN_REALLOC, 32'h100, 32'h10, 32'h20, 5'd4, r);
    send_req(FN_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31, r);
  endtask

  task automatic test_seed_and_alloc();
    alloc_res_t r;
    send_req(FN_FREE, 32'h1000_0004, 32'h0010_0000, 32'h0, 5'd0, r);
    do_alloc_tx(32'd100, 5'd1);
    do_alloc_tx(32'd1, 5'd4);
    do_alloc_tx(32'd0, 5'd1);
    do_alloc_tx(32'd4096, 5'd12);
    do_alloc_tx(32'd64, 5'd0);
    do_alloc_tx(32'hFFFF_FFFF, 5'd4);
    do_alloc_tx(32'h8000_0000, 5'd31);
    do_alloc_tx(32'd33, 5'd3);
    send_req(FN_RSVD, 32'h0, 32'h0, 32'h0, 5'd0, r);
  endtask

  task automatic test_resize();
    int n;
    n = live_chunks.size() - 1;
    do_realloc_tx(n, live_chunks[n].size);
    do_realloc_tx(n, live_chunks[n].size + 32'd40);
    do_realloc_tx(n, 32'd8);
    do_realloc_tx(n, 32'hFFFF_FFFF);
    do_realloc_tx(0, 32'h0100_0000);
    do_realloc_tx(0, 32'd0);
  endtask

  task automatic test_free_merge();
    while (live_chunks.size() > 0) do_free_tx(int'($urandom_range(live_chunks.size() - 1)));
  endtask

  task automatic test_table_full();
    alloc_res_t r;
    for (int i = 0; i < NEXT + 2; i++)
      send_req(FN_FREE, 32'h6000_0008 + i * 64, 32'd40, 32'h0, 5'd0, r);
    do_alloc_tx(32'h0000_1000, 5'd12);
    do_realloc_tx(live_chunks.size() - 1, 32'd8);
    do_alloc_tx(32'd8, 5'd4);
    send_req(FN_FREE, 32'h7000_0000, 32'd16, 32'h0, 5'd0, r);
  endtask

  task automatic test_saturation();
    alloc_res_t r;
    send_req(FN_FREE, 32'hFFFF_FFF0, 32'h20, 32'h0, 5'd0, r);
    send_req(FN_FREE, 32'h8000_0000, 32'h7FFF_FFF0, 32'h0, 5'd0, r);
    send_req(FN_FREE, 32'h2000_0000, 32'h6000_0000, 32'h0, 5'd0, r);
    do_alloc_tx(32'hF000_0000, 5'd1);
  endtask

  task automatic test_random(int n);
    int k;
    alloc_res_t r;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 10 || live_chunks.size() == 0 && k >= 45) begin
        send_req(2'($urandom_range(3)), $urandom, $urandom, $urandom, 5'($urandom), r);
      end else if (k < 45) begin
        if ($urandom_range(9) == 0) do_alloc_tx($urandom, 5'($urandom_range(1, 31)));
        else do_alloc_tx($urandom_range(1, 4096), 5'($urandom_range(1, 12)));
      end else if (k < 62) begin
        do_realloc_tx(int'($urandom_range(live_chunks.size() - 1)), $urandom_range(0, 8192));
      end else begin
        do_free_tx(int'($urandom_range(live_chunks.size() - 1)));
      end
    end
  endtask

  task automatic test_backpressure();
    rx_hold_req = 400;
    test_random(20);
    drain();
    test_random(20);
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FN_ALLOC;
    chunk_addr_i = '0;
    chunk_size_i = '0;
    new_size_i   = '0;
    align_log2_i = '0;
    out_ready_i  = 1'b0;
    pool_cnt     = 0;
    mismatches   = 0;
    stall_cycles = 0;
    rx_hold_req  = 0;
    rx_hold_left = 0;
    tx_idle_pct  = 15;
    rx_idle_pct  = 63;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pool();
    test_seed_and_alloc();
    test_resize();
    test_free_merge();
    test_table_full();
    test_saturation();
    test_random(600);
    tx_idle_pct = 63;
    rx_idle_pct = 15;
    test_backpressure();
    test_random(560);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(600);

    drain();
    repeat (500) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
